@@ rtl/dlre_pkg.sv @@
// Shared types and constants for the delegation line route extractor.
// No dependencies.
package dlre_pkg;

  localparam int unsigned MaxLine = 128;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] KIND_ROUTE = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam logic [1:0] REG_COUNTRY = 2'd0;
  localparam logic [1:0] REG_MAXLEN  = 2'd1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [32:0] CountSat = 33'h1_0000_0000;

  // "ipv4"
  function automatic logic [7:0] type_char(input logic [1:0] i);
    case (i)
      2'd0: type_char = 8'h69;
      2'd1: type_char = 8'h70;
      2'd2: type_char = 8'h76;
      default: type_char = 8'h34;
    endcase
  endfunction

  typedef struct packed {
    logic [15:0] country_code;
    logic [7:0]  max_line_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [32:0] count;
  } rec_t;

endpackage

@@ rtl/dlre_if.sv @@
// Channel interfaces: byte input, result output, register write port.
// Depends on nothing.
interface dlre_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
  modport monitor (input valid, input in_byte, input ready);
endinterface

interface dlre_route_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] prefix_addr;
  logic [5:0]  prefix_len;
  modport source (output valid, output result_kind, output prefix_addr, output prefix_len,
                  input ready);
  modport sink   (input valid, input result_kind, input prefix_addr, input prefix_len,
                  output ready);
  modport monitor (input valid, input result_kind, input prefix_addr, input prefix_len,
                   input ready);
endinterface

interface dlre_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [15:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
  modport monitor (input valid, input idx, input wdata, input ready);
endinterface

@@ rtl/dlre_front.sv @@
// Front: per-byte line parser, emits one record per line that yields a result.
// Depends on dlre_pkg.
module dlre_front (
  input  logic          clk,
  input  logic          rst_n,
  input  dlre_pkg::cfg_t cfg,
  input  logic          byte_valid,
  input  logic [7:0]    byte_in,
  output logic          byte_ready,
  input  logic          q_full,
  output logic          rec_push,
  output dlre_pkg::rec_t rec
);
  import dlre_pkg::*;

  typedef struct packed {
    logic [2:0]  fi;
    logic [7:0]  fp;
    logic [7:0]  ll;
    logic        cmt;
    logic        intok;
    logic        cc;
    logic        ty;
    logic        bad;
    logic        lng;
    logic [31:0] addr;
    logic [8:0]  oa;
    logic [2:0]  oc;
    logic [32:0] cnt;
  } st_t;

  st_t st_r, st_nxt;

  function automatic st_t finish_f(input st_t s);
    st_t r;
    r = s;
    case (s.fi)
      3'd2: if (s.fp < 8'd2) r.cc = 1'b0;
      3'd3: if (s.fp < 8'd4) r.ty = 1'b0;
      3'd4: begin
        if (!s.oa[8] || s.oc != 3'd3) r.bad = 1'b1;
        else r.addr = {s.addr[23:0], s.oa[7:0]};
      end
      3'd5: if (s.cnt == '0) r.bad = 1'b1;
      default: ;
    endcase
    r.intok = 1'b0;
    return r;
  endfunction

  function automatic st_t end_f(input st_t s);
    st_t r;
    r = s;
    if (r.intok) r = finish_f(r);
    if (r.fi < 3'd5) r.bad = 1'b1;
    r.fi = 3'd7;
    return r;
  endfunction

  function automatic st_t field_f(input st_t s, input logic [7:0] b, input logic [15:0] code);
    st_t         r;
    logic        dig;
    logic [11:0] v;
    logic [36:0] c;
    r = s;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    v = 12'({4'd0, s.oa[7:0]} * 12'd10) + 12'(b - CH_ZERO);
    c = 37'({4'd0, s.cnt} * 37'd10) + 37'(b - CH_ZERO);
    case (s.fi)
      3'd2: begin
        if (s.fp == 8'd0) r.cc = (b == code[15:8]);
        else if (s.fp == 8'd1 && b != code[7:0]) r.cc = 1'b0;
      end
      3'd3: begin
        if (s.fp == 8'd0) r.ty = (b == type_char(2'd0));
        else if (s.fp < 8'd4 && b != type_char(s.fp[1:0])) r.ty = 1'b0;
      end
      3'd4: begin
        if (dig) begin
          if (v > 12'd255) begin
            r.bad = 1'b1;
            v = 12'd255;
          end
          r.oa = {1'b1, v[7:0]};
        end else if (b == CH_DOT) begin
          if (!s.oa[8] || s.oc >= 3'd3) r.bad = 1'b1;
          else begin
            r.addr = {s.addr[23:0], s.oa[7:0]};
            r.oc = s.oc + 3'd1;
            r.oa = '0;
          end
        end else r.bad = 1'b1;
      end
      3'd5: begin
        if (!s.oa[0]) begin
          if (dig) r.cnt = (c > 37'(CountSat)) ? CountSat : c[32:0];
          else r.oa = 9'd1;
        end
      end
      default: ;
    endcase
    if (s.fp != 8'd255) r.fp = s.fp + 8'd1;
    return r;
  endfunction

  logic [7:0] limit;
  assign limit = (cfg.max_line_len < 8'(MaxLine)) ? cfg.max_line_len : 8'(MaxLine);

  // Stall the stream only while the record queue is full.
  assign byte_ready = !q_full;

  always_comb begin
    st_t s;
    s = st_r;
    rec_push = 1'b0;
    rec.kind = KIND_ROUTE;
    rec.addr = st_r.addr;
    rec.count = st_r.cnt;
    if (byte_valid && byte_ready) begin
      if (byte_in == CH_NL) begin
        if (!s.cmt) begin
          if (s.fi != 3'd7) s = end_f(s);
          rec.addr = s.addr;
          rec.count = s.cnt;
          if (s.lng) begin
            rec_push = 1'b1;
            rec.kind = KIND_LONG;
          end else if (s.cc && s.ty) begin
            rec_push = 1'b1;
            rec.kind = s.bad ? KIND_BAD : KIND_ROUTE;
          end
        end
        s = '0;
      end else begin
        if (s.ll == 8'd0 && byte_in == CH_HASH) s.cmt = 1'b1;
        if (s.ll >= limit) s.lng = 1'b1;
        if (s.ll != 8'd255) s.ll = s.ll + 8'd1;
        if (!(s.cmt || s.fi == 3'd7)) begin
          if (byte_in == CH_NUL) s = end_f(s);
          else if (byte_in == CH_PIPE) begin
            if (s.intok) s = finish_f(s);
          end else begin
            if (!s.intok) begin
              if (s.fi < 3'd6) s.fi = s.fi + 3'd1;
              s.fp = '0;
              s.oa = '0;
              s.intok = 1'b1;
            end
            s = field_f(s, byte_in, cfg.country_code);
          end
        end
      end
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else st_r <= st_nxt;
  end

endmodule

@@ rtl/dlre_fifo.sv @@
// Short record queue between parser front and result back end.
// Depends on dlre_pkg.
module dlre_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dlre_pkg::rec_t wr_rec,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output dlre_pkg::rec_t rd_rec
);
  import dlre_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  rec_t              mem_r [QueueDepth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     cnt_r;

  assign full = (cnt_r == (PtrW+1)'(QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign rd_rec = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrW'(QueueDepth-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PtrW'(QueueDepth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

@@ rtl/dlre_back.sv @@
// Back end: prefix length from the count, registered result output.
// Depends on dlre_pkg.
module dlre_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rec_avail,
  input  dlre_pkg::rec_t rec,
  output logic          rec_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    kind,
  output logic [31:0]   addr,
  output logic [5:0]    plen
);
  import dlre_pkg::*;

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [31:0] addr_r;
  logic [5:0]  plen_r;
  logic [32:0] m;
  logic [5:0]  bits;

  assign rec_pop = rec_avail && (!valid_r || out_ready);
  assign m = rec.count - 33'd1;

  // bit length of count-1 = ceil(log2(count))
  always_comb begin
    bits = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) bits = 6'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (rec_pop) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      kind_r <= rec.kind;
      if (rec.kind == KIND_ROUTE) begin
        addr_r <= rec.addr;
        plen_r <= (bits >= 6'd32) ? 6'd0 : 6'd32 - bits;
      end else begin
        addr_r <= '0;
        plen_r <= '0;
      end
    end
  end

  assign out_valid = valid_r;
  assign kind = kind_r;
  assign addr = addr_r;
  assign plen = plen_r;

endmodule

@@ rtl/delegation_line_route_extractor.sv @@
// Top level of the delegation line route extractor.
// Depends on dlre_pkg, dlre_if, dlre_front, dlre_fifo, dlre_back.

// Takes one stream byte per cycle. A newline that closes a non-comment line
// produces at most one result: a route (address, prefix length), a too-long
// error or a malformed error; other lines produce nothing. The newline's record
// is written into the queue, then loaded into the output register, which raises out_valid.
// Bytes are accepted every cycle while the two-entry record queue has room;
// only a stalled output can fill it.
// Registers: 0 country code (two ASCII letters, first in high byte), 1 maximum
// line length; write them only while the block is idle.
module delegation_line_route_extractor (
  input  logic         clk,
  input  logic         rst_n,
  dlre_byte_if.sink    in_ch,
  dlre_route_if.source out_ch,
  dlre_cfg_if.sink     cfg_ch
);
  import dlre_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_avail;
  rec_t q_wr, q_rd;

  // register file: always ready, unknown indexes dropped
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.country_code <= 16'h434E;
      cfg_r.max_line_len <= 8'd128;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_COUNTRY: cfg_r.country_code <= cfg_ch.wdata;
        REG_MAXLEN:  cfg_r.max_line_len <= cfg_ch.wdata[7:0];
        default: ;
      endcase
    end
  end

  dlre_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (in_ch.valid),
    .byte_in    (in_ch.in_byte),
    .byte_ready (in_ch.ready),
    .q_full     (q_full),
    .rec_push   (q_push),
    .rec        (q_wr)
  );

  dlre_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_rec    (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .rd_rec    (q_rd)
  );

  dlre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_avail (q_avail),
    .rec       (q_rd),
    .rec_pop   (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.result_kind),
    .addr      (out_ch.prefix_addr),
    .plen      (out_ch.prefix_len)
  );

endmodule
